// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared sizes, operation and status codes, and beat types for the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Number of entries in the element memory.
  localparam int unsigned CAPACITY = 64;
  // Width of a count that can hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Width of an element memory address.
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  // Width used to compare positions against the list length without overflow.
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W + 1 : 8;

  // Operation codes of an input beat; code 7 behaves as a query.
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_QUERY     = 3'd6
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Input beat.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [6:0]         position;
  } item_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic [6:0]         even_count;
    logic [6:0]         odd_count;
    logic signed [31:0] total;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic               found;
    logic [6:0]         occurrences;
  } result_t;

  // Running statistics over the list, handed from the scan unit to the top.
  typedef struct packed {
    logic [CNT_W-1:0]   evens;
    logic [CNT_W-1:0]   odds;
    logic [CNT_W-1:0]   hits;
    logic signed [31:0] sum;
    logic signed [31:0] big;
    logic signed [31:0] small_val;
  } stats_t;

endpackage

// File: sv/ple_stats.sv
// ----------------------------------------------------------------------------
// List statistics accumulator
// Folds one element per cycle into parity counts, sum, extremes and key hits.
// ----------------------------------------------------------------------------
module ple_stats (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 valid_i,
  input  logic signed [31:0]   data_i,
  input  logic signed [31:0]   key_i,
  output ple_pkg::stats_t      stats_o
);

  ple_pkg::stats_t acc_q, acc_d;
  logic            first_q, first_d;

  // Next accumulator value: start empty on clear, otherwise fold one element.
  always_comb begin
    acc_d   = acc_q;
    first_d = first_q;
    if (clear_i) begin
      acc_d.evens     = '0;
      acc_d.odds      = '0;
      acc_d.hits      = '0;
      acc_d.sum       = '0;
      acc_d.big       = -32'sd1;
      acc_d.small_val = -32'sd1;
      first_d         = 1'b1;
    end else if (valid_i) begin
      if (data_i[0]) begin
        acc_d.odds = acc_q.odds + ple_pkg::CNT_W'(1);
      end else begin
        acc_d.evens = acc_q.evens + ple_pkg::CNT_W'(1);
      end
      acc_d.sum = acc_q.sum + data_i;
      if (data_i == key_i) begin
        acc_d.hits = acc_q.hits + ple_pkg::CNT_W'(1);
      end
      // The first element seeds both extremes.
      if (first_q) begin
        acc_d.big       = data_i;
        acc_d.small_val = data_i;
      end else begin
        if (data_i > acc_q.big) begin
          acc_d.big = data_i;
        end
        if (data_i < acc_q.small_val) begin
          acc_d.small_val = data_i;
        end
      end
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign stats_o = acc_q;

endmodule

// File: sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// The list lives in a CAPACITY-entry element memory with one write port and
// one read port with registered read data. An accepted beat first checks its
// position and the fill level, then shifts the entries behind the target
// position one place (one entry per cycle through the read port), writes the
// new value for an insert, and finally scans the whole list to build the
// statistics. The single read port paces both the shift and the scan, and the
// finished result may wait for a free output register. A new beat is taken
// once the previous result has been placed in the output register, even while
// that result still waits to be taken.
module positional_list_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ple_pkg::item_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ple_pkg::result_t     out_data_o
);

  localparam int unsigned CNT_W = ple_pkg::CNT_W;
  localparam int unsigned IDX_W = ple_pkg::IDX_W;
  localparam int unsigned CMP_W = ple_pkg::CMP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [1:0]         status_q, status_d;
  logic               ins_q, ins_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic signed [31:0] key_q, key_d;
  logic [CNT_W-1:0]   moves_q, moves_d;
  logic [IDX_W-1:0]   rd_addr_q, rd_addr_d;
  logic               wb_q, wb_d;
  logic [IDX_W-1:0]   wb_addr_q, wb_addr_d;
  logic [CNT_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic               scan_vld_q, scan_vld_d;
  logic               out_valid_q, out_valid_d;
  ple_pkg::result_t   out_data_q, out_data_d;

  // Element memory and its port signals.
  logic [31:0]        mem [ple_pkg::CAPACITY];
  logic [31:0]        rdata_q;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [31:0]        wdata;

  logic               accept;
  logic               stats_clear;
  logic               shift_done;
  ple_pkg::stats_t    stats;

  // Decode helpers for the incoming beat.
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   len_w;
  logic [CMP_W-1:0]   tgt_w;
  logic               dec_ins;
  logic               dec_del;
  logic [1:0]         dec_status;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign stats_clear = accept;
  assign shift_done  = (moves_q == '0) && !wb_q;

  // Classify the beat and pick its target index and status.
  always_comb begin
    pos_w      = CMP_W'(in_data_i.position);
    len_w      = CMP_W'(len_q);
    tgt_w      = '0;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_status = ple_pkg::ST_OK;
    unique case (in_data_i.op)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
        dec_ins = 1'b1;
        tgt_w   = (in_data_i.op == ple_pkg::OP_INS_FRONT) ? '0 : len_w;
        if (len_w >= CMP_W'(ple_pkg::CAPACITY)) begin
          dec_status = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::OP_INS_AT: begin
        dec_ins = 1'b1;
        tgt_w   = pos_w - CMP_W'(1);
        if (pos_w == '0 || pos_w > len_w + CMP_W'(1)) begin
          dec_status = ple_pkg::ST_BADPOS;
        end else if (len_w >= CMP_W'(ple_pkg::CAPACITY)) begin
          dec_status = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
        dec_del = 1'b1;
        tgt_w   = (in_data_i.op == ple_pkg::OP_DEL_FRONT) ? '0 : len_w - CMP_W'(1);
        if (len_w == '0) begin
          dec_status = ple_pkg::ST_EMPTY;
        end
      end
      ple_pkg::OP_DEL_AT: begin
        dec_del = 1'b1;
        tgt_w   = pos_w - CMP_W'(1);
        if (pos_w == '0 || pos_w > len_w) begin
          dec_status = ple_pkg::ST_BADPOS;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: decode, shift, scan, hand over the result.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    status_d    = status_q;
    ins_d       = ins_q;
    idx_d       = idx_q;
    key_d       = key_q;
    moves_d     = moves_q;
    rd_addr_d   = rd_addr_q;
    wb_d        = 1'b0;
    wb_addr_d   = wb_addr_q;
    scan_cnt_d  = scan_cnt_q;
    scan_vld_d  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    raddr       = rd_addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d   = dec_status;
          ins_d      = dec_ins;
          idx_d      = IDX_W'(tgt_w);
          key_d      = in_data_i.value;
          scan_cnt_d = '0;
          if (dec_status == ple_pkg::ST_OK && dec_ins) begin
            // Entries tgt..len-1 move up, read from the top down.
            moves_d   = CNT_W'(len_w - tgt_w);
            rd_addr_d = IDX_W'(len_w - CMP_W'(1));
            state_d   = S_SHIFT;
          end else if (dec_status == ple_pkg::ST_OK && dec_del) begin
            // Entries tgt+1..len-1 move down, read from the bottom up.
            moves_d   = CNT_W'(len_w - CMP_W'(1) - tgt_w);
            rd_addr_d = IDX_W'(tgt_w + CMP_W'(1));
            state_d   = S_SHIFT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SHIFT: begin
        // Read one entry per cycle; it is written back one place over next cycle.
        if (moves_q != '0) begin
          raddr     = rd_addr_q;
          wb_d      = 1'b1;
          wb_addr_d = ins_q ? rd_addr_q + IDX_W'(1) : rd_addr_q - IDX_W'(1);
          rd_addr_d = ins_q ? rd_addr_q - IDX_W'(1) : rd_addr_q + IDX_W'(1);
          moves_d   = moves_q - CNT_W'(1);
        end else if (!wb_q) begin
          len_d   = ins_q ? len_q + CNT_W'(1) : len_q - CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Stream the list through the read port into the statistics unit.
        raddr = scan_cnt_q[IDX_W-1:0];
        if (scan_cnt_q != len_q) begin
          scan_vld_d = 1'b1;
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end else if (!scan_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Load the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.count       = 7'(len_q);
          out_data_d.even_count  = 7'(stats.evens);
          out_data_d.odd_count   = 7'(stats.odds);
          out_data_d.total       = stats.sum;
          out_data_d.largest     = stats.big;
          out_data_d.smallest    = stats.small_val;
          out_data_d.found       = (stats.hits != '0);
          out_data_d.occurrences = 7'(stats.hits);
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      status_q    <= '0;
      ins_q       <= 1'b0;
      idx_q       <= '0;
      key_q       <= '0;
      moves_q     <= '0;
      rd_addr_q   <= '0;
      wb_q        <= 1'b0;
      wb_addr_q   <= '0;
      scan_cnt_q  <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      status_q    <= status_d;
      ins_q       <= ins_d;
      idx_q       <= idx_d;
      key_q       <= key_d;
      moves_q     <= moves_d;
      rd_addr_q   <= rd_addr_d;
      wb_q        <= wb_d;
      wb_addr_q   <= wb_addr_d;
      scan_cnt_q  <= scan_cnt_d;
      scan_vld_q  <= scan_vld_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Write port: shifted entries first, then the inserted value at its slot.
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr_q;
    wdata = rdata_q;
    if (wb_q) begin
      we = 1'b1;
    end else if (state_q == S_SHIFT && shift_done && ins_q) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = key_q;
    end
  end

  // Element memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  ple_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (stats_clear),
    .valid_i (scan_vld_q),
    .data_i  (rdata_q),
    .key_i   (key_q),
    .stats_o (stats)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: bench/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list operations through the valid/ready input channel and checks
// every result beat field by field against a shadow copy of the list. A short
// scripted sequence covers the empty list, bad positions, unused opcodes and
// the value extremes. Random phases then grow, shrink or churn the list so
// that it reaches full and empty many times. Both sides idle at random.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 7 is not named in the package and acts as a query.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int NUM_SCRIPT   = 24;
  localparam int NUM_RANDOM   = 1500;
  localparam int PHASE_LEN    = 120;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 950;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [2:0] INS_OPS [3] =
    '{ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT};
  localparam logic [2:0] DEL_OPS [3] =
    '{ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT};
  localparam logic signed [31:0] LIMIT_VALUES [4] =
    '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};

  // Random phases bias the operation mix toward growing or shrinking the list.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_e;

  typedef struct {
    ple_pkg::item_t   beat;
    bit               typed;
    ple_pkg::result_t want;
  } script_row_t;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  ple_pkg::item_t   in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  ple_pkg::result_t out_data_o;

  bit                 calm = 1'b0;
  int unsigned        bad_fields = 0;
  logic signed [31:0] shadow_list [$];
  ple_pkg::result_t   pending_summaries [$];
  script_row_t        script [NUM_SCRIPT];

  positional_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock and a single reset pulse at the start.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Summary of an empty list with the given status.
  function automatic ple_pkg::result_t empty_list(input logic [1:0] st);
    return '{st, 7'd0, 7'd0, 7'd0, 32'sd0, -32'sd1, -32'sd1, 1'b0, 7'd0};
  endfunction

  // Applies one operation to the shadow list and returns the summary beat.
  function automatic ple_pkg::result_t apply_to_list(input ple_pkg::item_t it);
    ple_pkg::result_t   r;
    int unsigned        len;
    int unsigned        evens;
    int unsigned        odds;
    int unsigned        hits;
    logic signed [31:0] e;
    logic signed [31:0] sum;
    logic signed [31:0] big;
    logic signed [31:0] least;
    r     = '0;
    len   = shadow_list.size();
    evens = 0;
    odds  = 0;
    hits  = 0;
    sum   = '0;
    big   = -32'sd1;
    least = -32'sd1;
    r.status = ple_pkg::ST_OK;
    case (it.op)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
        if (len >= ple_pkg::CAPACITY) r.status = ple_pkg::ST_FULL;
        else if (it.op == ple_pkg::OP_INS_FRONT) shadow_list.push_front(it.value);
        else shadow_list.push_back(it.value);
      end
      ple_pkg::OP_INS_AT: begin
        // The position check wins over the full check.
        if (it.position < 1 || it.position > len + 1) r.status = ple_pkg::ST_BADPOS;
        else if (len >= ple_pkg::CAPACITY) r.status = ple_pkg::ST_FULL;
        else shadow_list.insert(it.position - 1, it.value);
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
        if (len == 0) r.status = ple_pkg::ST_EMPTY;
        else if (it.op == ple_pkg::OP_DEL_FRONT) void'(shadow_list.pop_front());
        else void'(shadow_list.pop_back());
      end
      ple_pkg::OP_DEL_AT: begin
        if (it.position < 1 || it.position > len) r.status = ple_pkg::ST_BADPOS;
        else shadow_list.delete(it.position - 1);
      end
      default: begin
      end
    endcase
    // Statistics over the list as it stands after the operation.
    foreach (shadow_list[i]) begin
      e = shadow_list[i];
      if (e[0]) odds++;
      else evens++;
      sum = sum + e;
      if (e == it.value) hits++;
      if (i == 0) begin
        big   = e;
        least = e;
      end else begin
        if (e > big) big = e;
        if (e < least) least = e;
      end
    end
    r.count       = 7'(shadow_list.size());
    r.even_count  = 7'(evens);
    r.odd_count   = 7'(odds);
    r.total       = sum;
    r.largest     = big;
    r.smallest    = least;
    r.found       = (hits != 0);
    r.occurrences = 7'(hits);
    return r;
  endfunction

  // Random operation shaped by the current phase and the list contents.
  function automatic ple_pkg::item_t make_item(input mix_e mix);
    ple_pkg::item_t it;
    int unsigned    roll;
    int unsigned    len;
    int unsigned    ins_pct;
    int unsigned    del_pct;
    len = shadow_list.size();
    case (mix)
      MIX_GROW: begin
        ins_pct = 75;
        del_pct = 15;
      end
      MIX_SHRINK: begin
        ins_pct = 15;
        del_pct = 75;
      end
      default: begin
        ins_pct = 40;
        del_pct = 40;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) it.op = INS_OPS[$urandom_range(0, 2)];
    else if (roll < ins_pct + del_pct) it.op = DEL_OPS[$urandom_range(0, 2)];
    else if (roll < 97) it.op = ple_pkg::OP_QUERY;
    else it.op = OP_UNUSED;
    // Small values repeat often, which exercises the occurrence count.
    roll = $urandom_range(0, 9);
    if (roll < 4) it.value = int'($urandom_range(0, 8)) - 4;
    else if (roll == 4) it.value = LIMIT_VALUES[$urandom_range(0, 3)];
    else if (roll < 7 && len != 0) it.value = shadow_list[$urandom_range(0, len - 1)];
    else it.value = $urandom;
    // Mostly legal positions, with a share of arbitrary ones.
    it.position = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 9) != 0) begin
      if (it.op == ple_pkg::OP_INS_AT) it.position = 7'($urandom_range(1, len + 1));
      else if (it.op == ple_pkg::OP_DEL_AT && len != 0)
        it.position = 7'($urandom_range(1, len));
    end
    return it;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      bad_fields++;
    end
  endtask

  task automatic check_summary(input ple_pkg::result_t got);
    ple_pkg::result_t want;
    if (pending_summaries.size() == 0) begin
      $display("%0t ns: beat expected none, got %h", $time, got);
      bad_fields++;
    end else begin
      want = pending_summaries.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("count", want.count, got.count);
      compare_field("even_count", want.even_count, got.even_count);
      compare_field("odd_count", want.odd_count, got.odd_count);
      compare_field("total", want.total, got.total);
      compare_field("largest", want.largest, got.largest);
      compare_field("smallest", want.smallest, got.smallest);
      compare_field("found", want.found, got.found);
      compare_field("occurrences", want.occurrences, got.occurrences);
    end
  endtask

  // Input side: scripted beats, then random phases, then the final verdict.
  initial begin : feed
    ple_pkg::item_t   beat;
    ple_pkg::result_t want;
    mix_e             mix;
    script = '{
      '{'{ple_pkg::OP_QUERY,     32'sd0,        7'd0},   1'b1,
        empty_list(ple_pkg::ST_OK)},
      '{'{ple_pkg::OP_DEL_FRONT, 32'sd0,        7'd0},   1'b1,
        empty_list(ple_pkg::ST_EMPTY)},
      '{'{ple_pkg::OP_DEL_BACK,  32'sd0,        7'd0},   1'b1,
        empty_list(ple_pkg::ST_EMPTY)},
      '{'{ple_pkg::OP_DEL_AT,    32'sd0,        7'd1},   1'b1,
        empty_list(ple_pkg::ST_BADPOS)},
      '{'{ple_pkg::OP_INS_AT,    32'sd5,        7'd0},   1'b1,
        empty_list(ple_pkg::ST_BADPOS)},
      '{'{ple_pkg::OP_INS_AT,    32'sd5,        7'd2},   1'b1,
        empty_list(ple_pkg::ST_BADPOS)},
      '{'{OP_UNUSED,             -32'sd1,       7'd127}, 1'b1,
        empty_list(ple_pkg::ST_OK)},
      '{'{ple_pkg::OP_INS_FRONT, 32'sh7FFFFFFF, 7'd0},   1'b1,
        '{ple_pkg::ST_OK, 7'd1, 7'd0, 7'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
          32'sh7FFFFFFF, 1'b1, 7'd1}},
      '{'{ple_pkg::OP_INS_BACK,  32'sh80000000, 7'd0},   1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    -32'sd1,       7'd2},   1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    32'sd0,        7'd1},   1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    32'sd2,        7'd5},   1'b0, '0},
      '{'{ple_pkg::OP_QUERY,     -32'sd1,       7'd0},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_AT,    32'sd0,        7'd0},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_AT,    32'sd0,        7'd6},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_AT,    32'sd0,        7'd127}, 1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    32'sd7,        7'd127}, 1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    32'sd7,        7'd7},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_AT,    32'sd2,        7'd3},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_FRONT, 32'sd0,        7'd0},   1'b0, '0},
      '{'{ple_pkg::OP_DEL_BACK,  -32'sd1,       7'd0},   1'b0, '0},
      '{'{OP_UNUSED,             32'sh7FFFFFFF, 7'd0},   1'b0, '0},
      '{'{ple_pkg::OP_INS_AT,    32'sh55555555, 7'd3},   1'b0, '0},
      '{'{ple_pkg::OP_QUERY,     32'sh55555555, 7'd0},   1'b0, '0}
    };
    mix = MIX_GROW;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int n = 0; n < NUM_SCRIPT + NUM_RANDOM; n++) begin
      if (n < NUM_SCRIPT) begin
        beat = script[n].beat;
      end else begin
        // The first random phase fills the store; later ones are drawn at random.
        if ((n - NUM_SCRIPT) % PHASE_LEN == 0)
          mix = (n == NUM_SCRIPT) ? MIX_GROW : mix_e'($urandom_range(0, 2));
        beat = make_item(mix);
      end
      while (!calm && $urandom_range(0, 99) < 19) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= beat;
      @(posedge clk_i);
      while (in_ready_o !== 1'b1) @(posedge clk_i);
      // The beat was taken at this edge.
      want = apply_to_list(beat);
      if (n < NUM_SCRIPT && script[n].typed) want = script[n].want;
      pending_summaries.push_back(want);
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
    end
    in_valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    // Any stray beat after the last expected one still gets caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_fields == 0) $display("positional_list_engine_tb: clean");
    else $display("positional_list_engine_tb: errors");
    $finish;
  end

  // Output side: check each beat taken, stall at random outside the calm window.
  initial begin : drain_results
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i) check_summary(out_data_o);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("positional_list_engine_tb: errors");
    $finish;
  end

endmodule
